// File: rtl/assert_macros.svh
// assertion macros for the window buffer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/iwrb_pkg.sv
`timescale 1ns / 1ps

package iwrb_pkg;

    localparam int WINDOW  = 64;
    localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int DATA_W  = 32;
    localparam int MODE_W  = 3;
    // power of two so the queue pointers wrap on their own
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH      = 3'd0,
        MODE_CLEAR     = 3'd1,
        MODE_READ_ALL  = 3'd2,
        MODE_READ_ACC  = 3'd3,
        MODE_READ_GYRO = 3'd4,
        MODE_READ_DT   = 3'd5,
        MODE_STATUS    = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        SEL_ALL  = 2'd0,
        SEL_ACC  = 2'd1,
        SEL_GYRO = 2'd2,
        SEL_DT   = 2'd3
    } t_sel;

    typedef struct packed {
        logic signed [DATA_W-1:0] acc_x;
        logic signed [DATA_W-1:0] acc_y;
        logic signed [DATA_W-1:0] acc_z;
        logic signed [DATA_W-1:0] gyro_x;
        logic signed [DATA_W-1:0] gyro_y;
        logic signed [DATA_W-1:0] gyro_z;
        logic signed [DATA_W-1:0] time_step;
    } t_sample;

    typedef struct packed {
        logic             single;
        logic             ok;
        logic [CNT_W-1:0] fill;
        logic             full;
        logic             wr;
        logic [IDX_W-1:0] addr;
        t_sel             sel;
        t_sample          smp;
    } t_cmd;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
        return (a == IDX_W'(WINDOW - 1)) ? '0 : a + 1'b1;
    endfunction

endpackage

// File: rtl/iwrb_front.sv
`timescale 1ns / 1ps

module iwrb_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [iwrb_pkg::MODE_W-1:0]     i_mode,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_acc_x,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_acc_y,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_acc_z,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_gyro_x,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_gyro_y,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_gyro_z,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_time_step,
    input  logic                            i_q_full,
    output logic                            o_stall,
    output logic                            o_push,
    output iwrb_pkg::t_cmd                  o_cmd
);
    import iwrb_pkg::*;

    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic             rd;

    assign o_stall = i_q_full;
    assign o_push  = i_valid & ~i_q_full;

    always_comb begin
        n_head        = r_head;
        n_count       = r_count;
        rd            = 1'b0;
        o_cmd.single  = 1'b1;
        o_cmd.ok      = 1'b1;
        o_cmd.wr      = 1'b0;
        o_cmd.addr    = r_head;
        o_cmd.sel     = SEL_ALL;
        o_cmd.smp     = '{i_acc_x, i_acc_y, i_acc_z, i_gyro_x, i_gyro_y, i_gyro_z,
                          i_time_step};
        case (t_mode'(i_mode))
            MODE_PUSH: begin
                o_cmd.wr = 1'b1;
                n_head   = wrap_inc(r_head);
                if (r_count != CNT_W'(WINDOW)) begin
                    n_count = r_count + 1'b1;
                end
            end
            MODE_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
            MODE_READ_ALL: begin
                rd        = 1'b1;
                o_cmd.sel = SEL_ALL;
            end
            MODE_READ_ACC: begin
                rd        = 1'b1;
                o_cmd.sel = SEL_ACC;
            end
            MODE_READ_GYRO: begin
                rd        = 1'b1;
                o_cmd.sel = SEL_GYRO;
            end
            MODE_READ_DT: begin
                rd        = 1'b1;
                o_cmd.sel = SEL_DT;
            end
            MODE_STATUS: begin
                o_cmd.ok = 1'b1;
            end
            default: begin
                o_cmd.ok = 1'b0;
            end
        endcase
        // reads stream only from a full window
        if (rd) begin
            if (r_count == CNT_W'(WINDOW)) begin
                o_cmd.single = 1'b0;
            end else begin
                o_cmd.ok = 1'b0;
            end
        end
        o_cmd.fill = n_count;
        o_cmd.full = (n_count == CNT_W'(WINDOW));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (o_push) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/iwrb_queue.sv
`timescale 1ns / 1ps

module iwrb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  iwrb_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output iwrb_pkg::t_cmd o_cmd
);
    import iwrb_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/iwrb_back.sv
`timescale 1ns / 1ps

module iwrb_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_empty,
    input  iwrb_pkg::t_cmd                     i_cmd,
    input  logic                               i_stall,
    output logic                               o_pop,
    output logic                               o_valid,
    output logic                               o_ok,
    output logic signed [iwrb_pkg::DATA_W-1:0] o_value0,
    output logic signed [iwrb_pkg::DATA_W-1:0] o_value1,
    output logic signed [iwrb_pkg::DATA_W-1:0] o_value2,
    output logic signed [iwrb_pkg::DATA_W-1:0] o_value3,
    output logic signed [iwrb_pkg::DATA_W-1:0] o_value4,
    output logic signed [iwrb_pkg::DATA_W-1:0] o_value5,
    output logic [iwrb_pkg::CNT_W-1:0]         o_fill_count,
    output logic                               o_is_full,
    output logic                               o_last
);
    import iwrb_pkg::*;

    typedef struct packed {
        logic             single;
        logic             ok;
        logic [CNT_W-1:0] fill;
        logic             full;
        logic             last;
        t_sel             sel;
    } t_meta;

    t_sample                  r_mem [WINDOW];
    t_sample                  r_rdata;
    t_meta                    r_s1;
    logic                     r_s1_valid;
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         r_addr;
    logic                     r_valid;
    logic                     r_ok;
    logic signed [DATA_W-1:0] r_value [6];
    logic signed [DATA_W-1:0] n_value [6];
    logic [CNT_W-1:0]         r_fill;
    logic                     r_full;
    logic                     r_last;

    logic             adv;
    logic             issue;
    logic             el_last;
    logic [IDX_W-1:0] cur_addr;

    assign adv      = ~(r_valid & i_stall);
    assign issue    = adv & ~i_q_empty;
    assign el_last  = i_cmd.single | (r_idx == IDX_W'(WINDOW - 1));
    assign cur_addr = (r_idx == '0) ? i_cmd.addr : r_addr;
    assign o_pop    = issue & el_last;

    always_ff @(posedge i_clk) begin
        if (issue && i_cmd.wr) begin
            r_mem[i_cmd.addr] <= i_cmd.smp;
        end
        if (adv) begin
            r_rdata <= r_mem[cur_addr];
        end
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_value[k] = '0;
        end
        if (!r_s1.single) begin
            case (r_s1.sel)
                SEL_ALL: begin
                    n_value[0] = r_rdata.acc_x;
                    n_value[1] = r_rdata.acc_y;
                    n_value[2] = r_rdata.acc_z;
                    n_value[3] = r_rdata.gyro_x;
                    n_value[4] = r_rdata.gyro_y;
                    n_value[5] = r_rdata.gyro_z;
                end
                SEL_ACC: begin
                    n_value[0] = r_rdata.acc_x;
                    n_value[1] = r_rdata.acc_y;
                    n_value[2] = r_rdata.acc_z;
                end
                SEL_GYRO: begin
                    n_value[0] = r_rdata.gyro_x;
                    n_value[1] = r_rdata.gyro_y;
                    n_value[2] = r_rdata.gyro_z;
                end
                SEL_DT: begin
                    n_value[0] = r_rdata.time_step;
                end
                default: begin
                    n_value[0] = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue && !el_last) begin
            r_addr <= wrap_inc(cur_addr);
        end
        if (adv) begin
            r_s1.single <= i_cmd.single;
            r_s1.ok     <= i_cmd.ok;
            r_s1.fill   <= i_cmd.fill;
            r_s1.full   <= i_cmd.full;
            r_s1.last   <= el_last;
            r_s1.sel    <= i_cmd.sel;
            r_ok        <= r_s1.ok;
            r_fill      <= r_s1.fill;
            r_full      <= r_s1.full;
            r_last      <= r_s1.last;
            for (int k = 0; k < 6; k++) begin
                r_value[k] <= n_value[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_valid <= issue;
                r_valid    <= r_s1_valid;
            end
            if (issue) begin
                if (el_last) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_ok         = r_ok;
    assign o_value0     = r_value[0];
    assign o_value1     = r_value[1];
    assign o_value2     = r_value[2];
    assign o_value3     = r_value[3];
    assign o_value4     = r_value[4];
    assign o_value5     = r_value[5];
    assign o_fill_count = r_fill;
    assign o_is_full    = r_full;
    assign o_last       = r_last;

endmodule

// File: rtl/imu_window_ring_buffer_unit.sv
// a taken request is queued, then registered in r_s1 and in the output registers
// push, clear, status and refused reads: one request per cycle unless stalled, one result each
// full-window read: WINDOW results at one per cycle unless stalled, paced by the single sample memory
// read port; the next request starts once the last of them has issued
// reset: head pointer, fill count, command queue and output pipeline valid flags cleared;
// the sample memory is not cleared and holds unknown data until written
`timescale 1ns / 1ps

module imu_window_ring_buffer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [iwrb_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_acc_x,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_acc_y,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_acc_z,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_gyro_x,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_gyro_y,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_gyro_z,
    input  logic signed [iwrb_pkg::DATA_W-1:0] i_time_step,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_ok,
    output logic signed [iwrb_pkg::DATA_W-1:0] o_value0,
    output logic signed [iwrb_pkg::DATA_W-1:0] o_value1,
    output logic signed [iwrb_pkg::DATA_W-1:0] o_value2,
    output logic signed [iwrb_pkg::DATA_W-1:0] o_value3,
    output logic signed [iwrb_pkg::DATA_W-1:0] o_value4,
    output logic signed [iwrb_pkg::DATA_W-1:0] o_value5,
    output logic [iwrb_pkg::CNT_W-1:0]         o_fill_count,
    output logic                               o_is_full,
    output logic                               o_last
);
    import iwrb_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic front_push;
    logic q_full;
    logic q_empty;
    logic q_pop;

    iwrb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_mode      (i_mode),
        .i_acc_x     (i_acc_x),
        .i_acc_y     (i_acc_y),
        .i_acc_z     (i_acc_z),
        .i_gyro_x    (i_gyro_x),
        .i_gyro_y    (i_gyro_y),
        .i_gyro_z    (i_gyro_z),
        .i_time_step (i_time_step),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (front_push),
        .o_cmd       (front_cmd)
    );

    iwrb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    iwrb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_cmd        (q_cmd),
        .i_stall      (i_stall),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .o_ok         (o_ok),
        .o_value0     (o_value0),
        .o_value1     (o_value1),
        .o_value2     (o_value2),
        .o_value3     (o_value3),
        .o_value4     (o_value4),
        .o_value5     (o_value5),
        .o_fill_count (o_fill_count),
        .o_is_full    (o_is_full),
        .o_last       (o_last)
    );

endmodule

// File: rtl/iwrb_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iwrb_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_stall,
    input logic                               o_valid,
    input logic                               o_ok,
    input logic signed [iwrb_pkg::DATA_W-1:0] o_value0,
    input logic signed [iwrb_pkg::DATA_W-1:0] o_value1,
    input logic signed [iwrb_pkg::DATA_W-1:0] o_value2,
    input logic signed [iwrb_pkg::DATA_W-1:0] o_value3,
    input logic signed [iwrb_pkg::DATA_W-1:0] o_value4,
    input logic signed [iwrb_pkg::DATA_W-1:0] o_value5,
    input logic [iwrb_pkg::CNT_W-1:0]         o_fill_count,
    input logic                               o_is_full,
    input logic                               o_last
);
    import iwrb_pkg::*;

    `ASSERT_AT(a_full_flag, i_clk, i_rst_n, o_valid |-> (o_is_full == (o_fill_count == CNT_W'(WINDOW))), "full flag disagrees with fill count")
    `ASSERT_AT(a_fill_range, i_clk, i_rst_n, o_valid |-> (o_fill_count <= CNT_W'(WINDOW)), "fill count above window")
    `ASSERT_AT(a_refused, i_clk, i_rst_n, (o_valid && !o_ok) |-> (o_last && o_value0 == 0 && o_value1 == 0 && o_value2 == 0 && o_value3 == 0 && o_value4 == 0 && o_value5 == 0), "refused request not a single zero result")
    `ASSERT_AT(a_stream_full, i_clk, i_rst_n, (o_valid && !o_last) |-> (o_ok && o_is_full), "stream result without a full window")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_value0) && $stable(o_last) && $stable(o_fill_count), "stalled result changed")

endmodule

bind imu_window_ring_buffer_unit iwrb_checker u_iwrb_checker (.*);
